/* sv/crt_pkg.sv */
// Shared types and constants for the command acknowledge/retry tracker.
// No dependencies; imported by every module of the block.
package crt_pkg;

   // Request command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_NEW  = 2'd1;
   localparam logic [1:0] CMD_ACK  = 2'd2;

   // Result action codes
   localparam logic ACTION_TRANSMIT = 1'b0;
   localparam logic ACTION_FINAL    = 1'b1;

   // Final status codes
   localparam logic [1:0] FINAL_ACKED   = 2'd0;
   localparam logic [1:0] FINAL_REFUSED = 2'd1;
   localparam logic [1:0] FINAL_EXPIRED = 2'd2;
   localparam logic [1:0] STATUS_NONE   = 2'd3;

   // Field widths fixed by the interface
   localparam int unsigned TARGET_W  = 48;
   localparam int unsigned CONSUMER_W = 32;
   localparam int unsigned OPCODE_W  = 8;
   localparam int unsigned RETRY_W   = 4;
   localparam int unsigned TIMEOUT_W = 16;
   localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

   // CSR map: one 32-bit register per word
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_ACK_TIMEOUT = 1'b0;
   localparam logic REG_RETRY_LIMIT = 1'b1;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 16'd2000;
   localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RESET = 4'd3;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [TARGET_W-1:0]   target_id;
      logic [CONSUMER_W-1:0] consumer_id;
      logic [OPCODE_W-1:0]   opcode;
      logic [7:0]            ack_code;
   } req_type;

   typedef struct packed {
      logic                  action;
      logic [1:0]            final_status;
      logic [TARGET_W-1:0]   out_target;
      logic [CONSUMER_W-1:0] out_consumer;
      logic [OPCODE_W-1:0]   out_opcode;
      logic [RETRY_W-1:0]    attempt;
   } rsp_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] ack_timeout;
      logic [RETRY_W-1:0]   retry_limit;
   } cfg_type;

endpackage

/* sv/crt_csr.sv */
// Configuration registers (ack timeout, retry limit) behind an APB-style port.
// Depends on crt_pkg.
module crt_csr
   import crt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [TIMEOUT_W-1:0] ack_timeout_ff;
   logic [RETRY_W-1:0]   retry_limit_ff;
   logic                 wr_en;
   logic                 reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_ACK_TIMEOUT: ack_timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
            REG_RETRY_LIMIT: retry_limit_ff <= csr_pwdata[RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_ACK_TIMEOUT: csr_prdata = CSR_DATA_W'(ack_timeout_ff);
         REG_RETRY_LIMIT: csr_prdata = CSR_DATA_W'(retry_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.ack_timeout = ack_timeout_ff;
   assign cfg.retry_limit = retry_limit_ff;

endmodule

/* sv/crt_engine.sv */
// Tracker state (pending command, timer, retry count) and the result register.
// Depends on crt_pkg.
module crt_engine
   import crt_pkg::*;
#(
   parameter int unsigned ID_BITS    = 48,
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  req_type item,
   output logic    item_take,
   input  cfg_type cfg,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // held id bits: target ids are compared in their low min(ID_BITS, TARGET_W) bits
   localparam int unsigned HELD_W = (ID_BITS < TARGET_W) ? ID_BITS : TARGET_W;
   localparam int unsigned CMP_W  = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   logic                  busy_ff,     busy_in;
   logic [HELD_W-1:0]     target_ff,   target_in;
   logic [CONSUMER_W-1:0] consumer_ff, consumer_in;
   logic [OPCODE_W-1:0]   opcode_ff,   opcode_in;
   logic [TIMER_BITS-1:0] elapsed_ff,  elapsed_in;
   logic [RETRY_W-1:0]    retry_ff,    retry_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff,       out_in;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic                  expired;
   logic                  retry_ok;
   logic                  id_match;
   logic                  emit;
   logic                  emit_action;
   logic [1:0]            emit_status;
   logic [RETRY_W-1:0]    emit_attempt;

   // an item moves on when the result register is free or being drained
   assign item_take = item_valid && (!out_valid_ff || rsp_ready);

   // saturating timer and compares
   assign elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff
                                                  : elapsed_ff + 1'b1;
   assign expired  = CMP_W'(elapsed_inc) >= CMP_W'(cfg.ack_timeout);
   assign retry_ok = (retry_ff < cfg.retry_limit) && (retry_ff != RETRY_MAX);
   assign id_match = (item.target_id[HELD_W-1:0] == target_ff)
                     && (item.consumer_id == consumer_ff)
                     && (item.opcode == opcode_ff);

   // next state and result for one request
   always_comb begin
      busy_in      = busy_ff;
      target_in    = target_ff;
      consumer_in  = consumer_ff;
      opcode_in    = opcode_ff;
      elapsed_in   = elapsed_ff;
      retry_in     = retry_ff;
      emit         = 1'b0;
      emit_action  = ACTION_TRANSMIT;
      emit_status  = STATUS_NONE;
      emit_attempt = retry_ff;
      unique case (item.cmd)
         CMD_TICK: begin
            if (busy_ff) begin
               elapsed_in = elapsed_inc;
               if (expired) begin
                  emit = 1'b1;
                  if (retry_ok) begin
                     retry_in     = retry_ff + 1'b1;
                     elapsed_in   = '0;
                     emit_attempt = retry_ff + 1'b1;
                  end else begin
                     busy_in     = 1'b0;
                     emit_action = ACTION_FINAL;
                     emit_status = FINAL_EXPIRED;
                  end
               end
            end
         end
         CMD_NEW: begin
            if (!busy_ff) begin
               busy_in      = 1'b1;
               target_in    = item.target_id[HELD_W-1:0];
               consumer_in  = item.consumer_id;
               opcode_in    = item.opcode;
               elapsed_in   = '0;
               retry_in     = '0;
               emit         = 1'b1;
               emit_attempt = '0;
            end
         end
         CMD_ACK: begin
            if (busy_ff && id_match) begin
               busy_in     = 1'b0;
               emit        = 1'b1;
               emit_action = ACTION_FINAL;
               emit_status = (item.ack_code == '0) ? FINAL_ACKED : FINAL_REFUSED;
            end
         end
         default: ;
      endcase
   end

   // result payload built from the held command after this update
   always_comb begin
      out_in.action       = emit_action;
      out_in.final_status = emit_status;
      out_in.out_target   = TARGET_W'(target_in);
      out_in.out_consumer = consumer_in;
      out_in.out_opcode   = opcode_in;
      out_in.attempt      = emit_attempt;
   end

   // result valid: load on take, clear when drained
   always_comb begin
      out_valid_in = out_valid_ff;
      if (item_take) begin
         out_valid_in = emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         elapsed_ff   <= '0;
         retry_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_take) begin
            busy_ff    <= busy_in;
            elapsed_ff <= elapsed_in;
            retry_ff   <= retry_in;
         end
      end
   end

   // held command and result payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         target_ff   <= target_in;
         consumer_ff <= consumer_in;
         opcode_ff   <= opcode_in;
         out_ff      <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* sv/command_ack_retry_tracker_top.sv */
// Top level of the command acknowledge/retry tracker: request register,
// tracker engine and CSR block. Depends on crt_pkg, crt_csr and crt_engine.
//
// Tracks one outstanding command in stop-and-wait fashion. A new command
// while idle is latched and produces a transmit result (attempt 0); tick
// requests advance a saturating timer and, on reaching ack_timeout, produce a
// retransmit (attempt = retry number) or, once the retry limit is used up, a
// final timeout status. A matching acknowledgement produces a final ack or nack.
// Requests that change nothing produce no result. Throughput is one request
// per clock while no result is held; a request's result passes through the
// one-deep request register, then the combinational tracker update, into the
// result register. A result held by rsp_ready low stalls the request register
// and with it req_ready. CSRs: ack_timeout at 0x0, retry limit at 0x4; write
// them only while the block is idle.
module command_ack_retry_tracker_top
   import crt_pkg::*;
#(
   parameter int unsigned ID_BITS    = 48,
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    item_take;
   cfg_type cfg;

   // request register: free when empty or moving on this cycle
   assign req_ready = !in_valid_ff || item_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   crt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crt_engine #(
      .ID_BITS    (ID_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_data_ff),
      .item_take  (item_take),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* verif/crt_checker.sv */
`timescale 1ns / 100ps
// Result checker for the command acknowledge/retry tracker: watches the request,
// result and CSR ports, predicts each result and compares it. Depends on crt_pkg.
module crt_checker
   import crt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int unsigned           awaiting,
   output int unsigned           mismatches
);

   // Shadow of the CSRs and of the single outstanding command
   cfg_type               cfg;
   logic                  cmd_open;
   logic [TARGET_W-1:0]   held_target;
   logic [CONSUMER_W-1:0] held_consumer;
   logic [OPCODE_W-1:0]   held_opcode;
   logic [TIMEOUT_W-1:0]  ticks_waited;
   logic [RETRY_W-1:0]    resends;

   rsp_type     due_results[$];
   int unsigned errors = 0;

   function automatic rsp_type held_result(input logic act, input logic [1:0] status,
                                           input logic [RETRY_W-1:0] try_no);
      rsp_type res;
      res.action       = act;
      res.final_status = status;
      res.out_target   = held_target;
      res.out_consumer = held_consumer;
      res.out_opcode   = held_opcode;
      res.attempt      = try_no;
      return res;
   endfunction

   // Advance the tracker by one request; returns 1 when a result is due
   function automatic bit track_command(input req_type r, output rsp_type res);
      res = '0;
      case (r.cmd)
         CMD_TICK: begin
            if (!cmd_open) return 1'b0;
            if (ticks_waited != '1) ticks_waited++;
            if (ticks_waited < cfg.ack_timeout) return 1'b0;
            if (resends < cfg.retry_limit && resends != RETRY_MAX) begin
               resends++;
               ticks_waited = '0;
               res = held_result(ACTION_TRANSMIT, STATUS_NONE, resends);
               return 1'b1;
            end
            cmd_open = 1'b0;
            res = held_result(ACTION_FINAL, FINAL_EXPIRED, resends);
            return 1'b1;
         end
         CMD_NEW: begin
            if (cmd_open) return 1'b0;
            held_target   = r.target_id;
            held_consumer = r.consumer_id;
            held_opcode   = r.opcode;
            ticks_waited  = '0;
            resends       = '0;
            cmd_open      = 1'b1;
            res = held_result(ACTION_TRANSMIT, STATUS_NONE, '0);
            return 1'b1;
         end
         CMD_ACK: begin
            if (!cmd_open || r.target_id != held_target || r.consumer_id != held_consumer
                || r.opcode != held_opcode) return 1'b0;
            cmd_open = 1'b0;
            res = held_result(ACTION_FINAL, (r.ack_code == '0) ? FINAL_ACKED : FINAL_REFUSED,
                              resends);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Sample all three ports on the clock edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type res;
      if (reset) begin
         cfg.ack_timeout = ACK_TIMEOUT_RESET;
         cfg.retry_limit = RETRY_LIMIT_RESET;
         cmd_open        = 1'b0;
         held_target     = '0;
         held_consumer   = '0;
         held_opcode     = '0;
         ticks_waited    = '0;
         resends         = '0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("action", want.action, rsp_data.action);
               check_field("final_status", want.final_status, rsp_data.final_status);
               check_field("out_target", want.out_target, rsp_data.out_target);
               check_field("out_consumer", want.out_consumer, rsp_data.out_consumer);
               check_field("out_opcode", want.out_opcode, rsp_data.out_opcode);
               check_field("attempt", want.attempt, rsp_data.attempt);
            end
         end
         if (req_valid && req_ready) begin
            if (track_command(req_data, res)) due_results.push_back(res);
         end
         // CSR writes update the shadow; reads are compared against it
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_W-1:2] == REG_ACK_TIMEOUT)
                  cfg.ack_timeout = csr_pwdata[TIMEOUT_W-1:0];
               else
                  cfg.retry_limit = csr_pwdata[RETRY_W-1:0];
            end else if (csr_paddr[CSR_ADDR_W-1:2] == REG_ACK_TIMEOUT) begin
               check_field("ack_timeout read", cfg.ack_timeout, csr_prdata[TIMEOUT_W-1:0]);
            end else begin
               check_field("retry_limit read", cfg.retry_limit, csr_prdata[RETRY_W-1:0]);
            end
         end
      end
      awaiting   <= due_results.size();
      mismatches <= errors;
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the command acknowledge/retry tracker: clock, reset, request
// and CSR stimulus, result back-pressure and verdict. Depends on crt_pkg, crt_checker.
module tb;
   import crt_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned STALL_LIMIT    = 2000;
   localparam int unsigned PHASES         = 9;
   localparam int unsigned PHASE_REQUESTS = 150;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           awaiting;
   int unsigned           mismatches;

   int unsigned          send_gap_pct = 6;
   int unsigned          take_gap_pct = 81;
   logic [TIMEOUT_W-1:0] cur_timeout  = ACK_TIMEOUT_RESET;
   logic [RETRY_W-1:0]   cur_retries  = RETRY_LIMIT_RESET;
   req_type              last_cmd     = '0;

   command_ack_retry_tracker_top DUT (.*);
   crt_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result back-pressure
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= take_gap_pct);

   function automatic req_type random_request(input logic [1:0] code);
      req_type r;
      r.cmd         = code;
      r.target_id   = TARGET_W'({$urandom(), $urandom()});
      r.consumer_id = $urandom();
      r.opcode      = OPCODE_W'($urandom());
      r.ack_code    = 8'($urandom());
      case ($urandom_range(7))
         0: begin
            r.target_id = '0; r.consumer_id = '0; r.opcode = '0;
         end
         1: begin
            r.target_id = '1; r.consumer_id = '1; r.opcode = '1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Requests the tracker should ignore or that hit it out of order
   function automatic req_type noise_request();
      req_type r;
      r = random_request(CMD_TICK);
      case ($urandom_range(3))
         0: r.cmd = 2'd3;
         1: r.cmd = CMD_NEW;
         2: begin
            r = last_cmd;
            r.cmd = CMD_ACK;
            case ($urandom_range(2))
               0: r.target_id ^= TARGET_W'(1) << $urandom_range(TARGET_W-1);
               1: r.consumer_id ^= CONSUMER_W'(1) << $urandom_range(CONSUMER_W-1);
               default: r.opcode ^= OPCODE_W'(1) << $urandom_range(OPCODE_W-1);
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one request and hold it until accepted
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [TIMEOUT_W-1:0] timeout, input logic [RETRY_W-1:0] retries);
      cur_timeout = timeout;
      cur_retries = retries;
      csr_access(1'b1, REG_ACK_TIMEOUT, CSR_DATA_W'(timeout));
      csr_access(1'b1, REG_RETRY_LIMIT, CSR_DATA_W'(retries));
      csr_access(1'b0, REG_ACK_TIMEOUT, '0);
      csr_access(1'b0, REG_RETRY_LIMIT, '0);
   endtask

   // Stop sending, wait for every expected result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Command / tick / ack sequences with noise mixed in
   task automatic run_traffic(input int unsigned budget);
      int unsigned sent;
      int unsigned span;
      int unsigned ticks;
      req_type     r;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 12) begin
            send_request(noise_request());
            sent++;
         end else begin
            last_cmd = random_request(CMD_NEW);
            send_request(last_cmd);
            sent++;
            span = (cur_timeout == 0) ? 1 : ((cur_timeout > 16) ? 16 : int'(cur_timeout));
            span = span * (int'(cur_retries) + 1) + 2;
            ticks = $urandom_range(span);
            // keep the phase close to its request budget
            if (sent + ticks > budget) ticks = budget - sent;
            repeat (ticks) begin
               if ($urandom_range(99) < 8) begin
                  send_request(noise_request());
               end else begin
                  send_request(random_request(CMD_TICK));
               end
               sent++;
            end
            if ($urandom_range(99) < 80) begin
               r = last_cmd;
               r.cmd = CMD_ACK;
               r.ack_code = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
               send_request(r);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      req_type     r;
      int unsigned phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one-tick timeout, two retries
      configure(16'd1, 4'd2);
      r = random_request(CMD_TICK);
      send_request(r);                  // tick while idle
      r.cmd = CMD_ACK;
      send_request(r);                  // ack while idle
      r = '1;
      send_request(r);                  // unused command code
      r = '0;
      r.cmd = CMD_NEW;
      send_request(r);                  // all-zero command
      last_cmd = r;
      r = '1;
      r.cmd = CMD_NEW;
      send_request(r);                  // command while busy
      r = last_cmd;
      r.cmd = CMD_ACK;
      r.target_id = '1;
      send_request(r);                  // ack, wrong target
      r.target_id = '0;
      r.consumer_id = 32'h1;
      send_request(r);                  // ack, wrong consumer
      r.consumer_id = '0;
      r.opcode = 8'h80;
      send_request(r);                  // ack, wrong opcode
      repeat (3) send_request(random_request(CMD_TICK));  // two resends, then timeout
      r = '1;
      r.cmd = CMD_NEW;
      send_request(r);                  // all-ones command
      r.cmd = CMD_ACK;
      send_request(r);                  // nack with status 0xff
      last_cmd = random_request(CMD_NEW);
      send_request(last_cmd);
      r = last_cmd;
      r.cmd = CMD_ACK;
      r.ack_code = '0;
      send_request(r);                  // clean ack on first attempt
      last_cmd = random_request(CMD_NEW);
      send_request(last_cmd);
      send_request(random_request(CMD_TICK));
      r = last_cmd;
      r.cmd = CMD_ACK;
      r.ack_code = 8'h01;
      send_request(r);                  // nack after one resend
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            send_gap_pct = 81;
            take_gap_pct = 6;
         end else if (phase == 6) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end
         case (phase)
            0: configure(16'd0, 4'd15);
            1: configure(16'd1, 4'd0);
            2: configure(16'd2, 4'd1);
            3: configure(16'hFFFF, 4'd15);
            4: configure(16'd7, 4'd3);
            5: configure(16'd3, 4'd15);
            6: configure(ACK_TIMEOUT_RESET, RETRY_LIMIT_RESET);
            default: configure(16'($urandom_range(12, 1)), 4'($urandom_range(15)));
         endcase
         run_traffic(PHASE_REQUESTS);
         settle();
      end

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Ends the run when no port moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
